// File: design/u2l_pkg.sv
// Package with shared types and constants for the UTF-8 to Latin-1 stream converter.
`timescale 1ns / 1ps
package u2l_pkg;

    localparam logic [7:0] QMARK_CHAR  = 8'h3F;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_BITS   = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_BITS  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_BITS  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_BITS  = 8'hF0;
    localparam logic [7:0] LEAD2_DATA  = 8'h1F;
    localparam logic [7:0] LEAD3_DATA  = 8'h0F;
    localparam logic [7:0] LEAD4_DATA  = 8'h07;
    localparam logic [7:0] CONT_DATA   = 8'h3F;

    localparam int QUEUE_DEPTH = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_string;
    } res_t;

    // results of one input item
    typedef struct packed {
        logic [1:0] num;
        res_t       first;
        res_t       second;
    } dec_t;

endpackage

// File: design/u2l_decoder.sv
// Decoder: UTF-8 sequence state and per-item result generation.
`timescale 1ns / 1ps
module u2l_decoder (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic [7:0]    in_byte,
    input  logic          end_of_string,
    output u2l_pkg::dec_t dec
);
    import u2l_pkg::*;

    // partial code point kept as its low 8 bits plus a flag for any higher bit set
    logic [7:0] lo_reg, lo_next;
    logic       big_reg, big_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [7:0] cont_lo;
    logic       cont_big;
    logic [1:0] cont_cnt;
    logic       flushed;
    res_t       lead_res;
    logic       lead_emit;

    always_comb begin
        dec       = '0;
        lo_next   = lo_reg;
        big_next  = big_reg;
        cnt_next  = cnt_reg;
        cont_lo   = {lo_reg[1:0], in_byte[5:0] & CONT_DATA[5:0]};
        cont_big  = big_reg | (lo_reg[7:2] != 6'd0);
        cont_cnt  = cnt_reg - 2'd1;
        flushed   = 1'b0;
        lead_res  = '0;
        lead_emit = 1'b0;

        if ((cnt_reg != 2'd0) && ((in_byte & CONT_MASK) == CONT_BITS)) begin
            if ((cont_cnt == 2'd0) || end_of_string) begin
                dec.num                  = 2'd1;
                dec.first.out_byte       = cont_big ? QMARK_CHAR : cont_lo;
                dec.first.last_of_string = end_of_string;
                lo_next  = '0;
                big_next = 1'b0;
                cnt_next = 2'd0;
            end else begin
                lo_next  = cont_lo;
                big_next = cont_big;
                cnt_next = cont_cnt;
            end
        end else begin
            if (cnt_reg != 2'd0) begin
                flushed                  = 1'b1;
                dec.first.out_byte       = big_reg ? QMARK_CHAR : lo_reg;
                dec.first.last_of_string = 1'b0;
            end
            lo_next  = '0;
            big_next = 1'b0;
            cnt_next = 2'd0;
            lead_res.last_of_string = end_of_string;
            if (!in_byte[7]) begin
                lead_emit         = 1'b1;
                lead_res.out_byte = in_byte;
            end else if ((in_byte & LEAD2_MASK) == LEAD2_BITS) begin
                lo_next  = in_byte & LEAD2_DATA;
                cnt_next = 2'd1;
            end else if ((in_byte & LEAD3_MASK) == LEAD3_BITS) begin
                lo_next  = in_byte & LEAD3_DATA;
                cnt_next = 2'd2;
            end else if ((in_byte & LEAD4_MASK) == LEAD4_BITS) begin
                lo_next  = in_byte & LEAD4_DATA;
                cnt_next = 2'd3;
            end else begin
                lead_emit         = 1'b1;
                lead_res.out_byte = QMARK_CHAR;
            end
            // lead cut by end of string: its few data bits always fit Latin-1
            if (!lead_emit && end_of_string) begin
                lead_emit         = 1'b1;
                lead_res.out_byte = lo_next;
                lo_next  = '0;
                cnt_next = 2'd0;
            end
            if (flushed) begin
                dec.num    = lead_emit ? 2'd2 : 2'd1;
                dec.second = lead_res;
            end else begin
                dec.num   = lead_emit ? 2'd1 : 2'd0;
                dec.first = lead_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg  <= '0;
            big_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else if (fire) begin
            lo_reg  <= lo_next;
            big_reg <= big_next;
            cnt_reg <= cnt_next;
        end
    end

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && end_of_string |=> cnt_reg == 2'd0)
        else $error("sequence still pending after end of string");

    a_eos_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && end_of_string |-> dec.num != 2'd0)
        else $error("end of string produced no item");

endmodule

// File: design/u2l_out_queue.sv
// Three-entry shift queue that holds result items for the output channel.
`timescale 1ns / 1ps
module u2l_out_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  u2l_pkg::dec_t dec,
    output logic          room,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_byte
    output logic          m_tlast
);
    import u2l_pkg::*;

    res_t       q_reg  [QUEUE_DEPTH];
    res_t       q_next [QUEUE_DEPTH];
    res_t       shifted [QUEUE_DEPTH];
    logic [1:0] count_reg, count_next;
    logic [1:0] base;
    logic [1:0] push_n;
    logic       pop;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q_reg[0].out_byte;
    assign m_tlast  = q_reg[0].last_of_string;
    assign pop      = m_tvalid && m_tready;
    assign room     = (count_reg <= 2'd1);
    assign push_n   = push ? dec.num : 2'd0;
    assign base     = count_reg - {1'b0, pop};

    always_comb begin
        shifted[0] = pop ? q_reg[1] : q_reg[0];
        shifted[1] = pop ? q_reg[2] : q_reg[1];
        shifted[2] = q_reg[2];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_next[i] = shifted[i];
            if ((push_n != 2'd0) && (2'(i) == base)) begin
                q_next[i] = dec.first;
            end else if ((push_n == 2'd2) && (2'(i) == base + 2'd1)) begin
                q_next[i] = dec.second;
            end
        end
        count_next = base + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_n != 2'd0 |-> count_reg <= 2'd1)
        else $error("push into full queue");

    a_push_num: assert property (@(posedge aclk) disable iff (!aresetn)
        push_n != 2'd3)
        else $error("more than two items from one input");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> count_reg == 2'd0)
        else $error("queue not empty after reset");

endmodule

// File: design/utf8_to_latin1_stream.sv
// Top level: UTF-8 byte stream to Latin-1 byte stream converter.
// An accepted item is held in the input register, then in the result queue, before its first result shows on m_.
// Throughput: one input item per cycle while the result queue has room; an item that gives two results
// takes two entries of the three-entry result queue.
// Reset (aresetn low, synchronous) empties input register and queue and
// clears any pending UTF-8 sequence.
`timescale 1ns / 1ps
module utf8_to_latin1_stream (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import u2l_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       room;
    logic       fire;
    dec_t       dec;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    u2l_decoder u_decoder (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .in_byte       (in_byte_reg),
        .end_of_string (in_last_reg),
        .dec           (dec)
    );

    u2l_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fire),
        .dec      (dec),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
